// File: design/qmi_pkg.sv
// Package for the queue with middle insertion: action and status codes,
// the command kind and the command record passed from front to back.
// No dependencies.
package qmi_pkg;

  // Action codes on the input tuser
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;

  // Status codes on the output tuser
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int unsigned ValueW = 32;
  localparam int unsigned OccW   = 11;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_POP,
    CMD_INSERT,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [ValueW-1:0]  value;
  } cmd_t;

endpackage

// File: design/qmi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module qmi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/qmi_front.sv
// Front end: accepts input transactions and classifies the action into a command.
// Depends on qmi_pkg.
module qmi_front
  import qmi_pkg::*;
(
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [31:0] value
  input  logic [1:0]        s_axis_tuser,   // [1:0] action
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              q_cmd_o
);

  // Take a transaction whenever the command queue has room
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  // Decode the action code; the unused code becomes a no-op
  always_comb begin
    q_cmd_o.value = s_axis_tdata;
    case (s_axis_tuser)
      ACT_APPEND: q_cmd_o.kind = CMD_APPEND;
      ACT_POP:    q_cmd_o.kind = CMD_POP;
      ACT_INSERT: q_cmd_o.kind = CMD_INSERT;
      default:    q_cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// File: design/qmi_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on qmi_pkg.
module qmi_cmd_fifo
  import qmi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: design/qmi_back.sv
// Back end: executes commands on the front and back rings, keeps the split
// balanced and drives the result register. Depends on qmi_pkg and qmi_ram.
module qmi_back
  import qmi_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] result_value, [42:32] occupancy
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;

  localparam logic S_EXEC = 1'b0;
  localparam logic S_MOVE = 1'b1;

  logic          state_q, state_d;
  logic [AW-1:0] front_head_q, front_head_d;
  logic [AW-1:0] back_head_q, back_head_d;
  logic [CW-1:0] front_count_q, front_count_d;
  logic [CW-1:0] back_count_q, back_count_d;
  logic          mv_write_q, mv_write_d;
  logic          mv_pop_q, mv_pop_d;
  logic [AW-1:0] mv_addr_q, mv_addr_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] out_value_q, out_value_d;
  logic [1:0]               out_status_q, out_status_d;
  logic [OccW-1:0]          out_occ_q, out_occ_d;

  logic [CW-1:0]     total;
  logic              even, empty, full, start;
  logic [SW-1:0]     fsum, bsum;
  logic [AW-1:0]     front_tail, back_tail;
  logic [AW-1:0]     front_head_inc, back_head_inc, back_head_dec;

  logic              fr_we, br_we;
  logic [AW-1:0]     fr_waddr, fr_raddr, br_waddr, br_raddr;
  logic [ValueW-1:0] fr_wdata, fr_rdata, br_wdata, br_rdata;

  // Ring slot arithmetic
  assign total = CW'(front_count_q + back_count_q);
  assign even  = ~total[0];
  assign empty = (total == '0);
  assign full  = (total == CW'(DEPTH));

  assign fsum = {2'b00, front_head_q} + SW'(front_count_q);
  assign bsum = {2'b00, back_head_q} + SW'(back_count_q);
  assign front_tail = (fsum >= SW'(DEPTH)) ? AW'(fsum - SW'(DEPTH)) : fsum[AW-1:0];
  assign back_tail  = (bsum >= SW'(DEPTH)) ? AW'(bsum - SW'(DEPTH)) : bsum[AW-1:0];

  assign front_head_inc = (front_head_q == AW'(DEPTH - 1)) ? '0 : front_head_q + 1'b1;
  assign back_head_inc  = (back_head_q == AW'(DEPTH - 1)) ? '0 : back_head_q + 1'b1;
  assign back_head_dec  = (back_head_q == '0) ? AW'(DEPTH - 1) : back_head_q - 1'b1;

  // Start a command only when the result register can take its result
  assign start   = (state_q == S_EXEC) && q_valid_i && (!out_valid_q || m_axis_tready);
  assign q_pop_o = start;

  // Execute a command, then finish any ring crossing and return a popped value in the move state
  always_comb begin
    state_d       = state_q;
    front_head_d  = front_head_q;
    back_head_d   = back_head_q;
    front_count_d = front_count_q;
    back_count_d  = back_count_q;
    mv_write_d    = mv_write_q;
    mv_pop_d      = mv_pop_q;
    mv_addr_d     = mv_addr_q;
    fr_we         = 1'b0;
    fr_waddr      = front_tail;
    fr_wdata      = q_cmd_i.value;
    fr_raddr      = front_head_q;
    br_we         = 1'b0;
    br_waddr      = back_tail;
    br_wdata      = q_cmd_i.value;
    br_raddr      = back_head_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;
    out_occ_d     = out_occ_q;

    case (state_q)
      S_EXEC: begin
        if (start) begin
          out_value_d  = '0;
          out_status_d = STAT_OK;
          out_valid_d  = 1'b1;
          mv_write_d   = 1'b0;
          mv_pop_d     = 1'b0;
          mv_addr_d    = front_tail;
          case (q_cmd_i.kind)
            CMD_APPEND: begin
              if (full) begin
                out_status_d = STAT_FULL;
              end else if (even && empty) begin
                // Sole entry lands in the front ring
                fr_we         = 1'b1;
                front_count_d = front_count_q + 1'b1;
              end else if (even) begin
                // Append at the back tail, move the back head to the front
                br_we         = 1'b1;
                back_head_d   = back_head_inc;
                front_count_d = front_count_q + 1'b1;
                mv_write_d    = 1'b1;
                out_valid_d   = 1'b0;
                state_d       = S_MOVE;
              end else begin
                br_we        = 1'b1;
                back_count_d = back_count_q + 1'b1;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                out_status_d = STAT_FULL;
              end else if (even) begin
                // Middle slot is the front tail
                fr_we         = 1'b1;
                front_count_d = front_count_q + 1'b1;
              end else begin
                // Middle slot is just ahead of the back head
                br_we        = 1'b1;
                br_waddr     = back_head_dec;
                back_head_d  = back_head_dec;
                back_count_d = back_count_q + 1'b1;
              end
            end
            CMD_POP: begin
              if (empty) begin
                out_status_d = STAT_EMPTY;
              end else begin
                front_head_d = front_head_inc;
                mv_pop_d     = 1'b1;
                out_valid_d  = 1'b0;
                state_d      = S_MOVE;
                if (even) begin
                  // Refill the front tail from the back head
                  back_head_d  = back_head_inc;
                  back_count_d = back_count_q - 1'b1;
                  mv_write_d   = 1'b1;
                end else begin
                  front_count_d = front_count_q - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          out_occ_d = OccW'(CW'(front_count_d + back_count_d));
        end
      end
      S_MOVE: begin
        fr_we        = mv_write_q;
        fr_waddr     = mv_addr_q;
        fr_wdata     = br_rdata;
        out_valid_d  = 1'b1;
        out_value_d  = mv_pop_q ? fr_rdata : '0;
        out_status_d = STAT_OK;
        out_occ_d    = OccW'(total);
        state_d      = S_EXEC;
      end
      default: begin
        state_d = S_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_EXEC;
      front_head_q  <= '0;
      back_head_q   <= '0;
      front_count_q <= '0;
      back_count_q  <= '0;
      mv_write_q    <= 1'b0;
      mv_pop_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      front_head_q  <= front_head_d;
      back_head_q   <= back_head_d;
      front_count_q <= front_count_d;
      back_count_q  <= back_count_d;
      mv_write_q    <= mv_write_d;
      mv_pop_q      <= mv_pop_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Result payload and move address
  always_ff @(posedge clk_i) begin
    mv_addr_q    <= mv_addr_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  qmi_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_front_ring (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  qmi_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_back_ring (
    .clk_i   (clk_i),
    .we_i    (br_we),
    .waddr_i (br_waddr),
    .wdata_i (br_wdata),
    .raddr_i (br_raddr),
    .rdata_o (br_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_occ_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// File: design/queue_with_middle_insertion_top.sv
// Queue with middle insertion. A command leaving the command queue gives its result
// through the result register; a pop of a stored entry or an append that moves an entry
// from the back ring to the front ring passes through the move state first (RAM read).
// No new command is taken during the move state or while a result waits unaccepted.
// Reset clears ring heads, counts and all handshake state; ring RAM contents are
// not cleared and need no clearing pass.
module queue_with_middle_insertion_top
  import qmi_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] result_value, [42:32] occupancy
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  qmi_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  qmi_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  qmi_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
